[hw/rtl/rgb2lab_pkg.sv]
package rgb2lab_pkg;

  localparam int PIX_W   = 8;
  localparam int LIN_W   = 17;
  localparam int COEF_W  = 16;
  localparam int PROD_W  = LIN_W + COEF_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int NUM_W   = ACC_W + 7;
  localparam int WHITE_W = 17;
  localparam int DEN_W   = WHITE_W + 6;
  localparam int RATIO_W = 24;
  localparam int F_W     = 19;
  localparam int L_W     = 7;
  localparam int AB_W    = 8;
  localparam int TAB_N   = 256;

  localparam int DIV_STAGES  = RATIO_W / 2;
  localparam int CBRT_STAGES = F_W;

  // linear segment of f() below 0.008856
  localparam int unsigned F_KNEE    = 581;
  localparam int unsigned F_SLOPE   = 510329;
  localparam int unsigned F_OFFSET  = 9039;
  localparam int          KNEE_W    = 10;

  localparam logic [WHITE_W-1:0] WHITE_X_RST = 17'd97328;
  localparam logic [WHITE_W-1:0] WHITE_Y_RST = 17'd102400;
  localparam logic [WHITE_W-1:0] WHITE_Z_RST = 17'd111496;

  typedef enum logic [1:0] {
    CFG_WHITE_X = 2'd0,
    CFG_WHITE_Y = 2'd1,
    CFG_WHITE_Z = 2'd2
  } cfg_idx_t;

  typedef logic [COEF_W-1:0] coef_row_t [3];
  typedef coef_row_t         coef_mat_t [3];

  localparam coef_mat_t COEF = '{
    '{16'd27031, 16'd23434, 16'd11824},
    '{16'd13938, 16'd46869, 16'd4730},
    '{16'd1267,  16'd7811,  16'd62274}
  };

  typedef logic [LIN_W-1:0] lin_tab_t [TAB_N];

  function automatic longint unsigned pow5_q30(longint unsigned y);
    longint unsigned p;
    p = y;
    for (int k = 0; k < 4; k++) begin
      p = (p * y) >> 30;
    end
    return p;
  endfunction

  function automatic lin_tab_t build_lin_tab();
    lin_tab_t tab;
    longint unsigned t;
    longint unsigned t2;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned v;
    for (int i = 0; i < TAB_N; i++) begin
      if (i <= 10) begin
        v = (longint'(i) * 13107200 + 329460) / 658920;
      end else begin
        t  = (longint'(40 * i + 561) << 30) / 10761;
        t2 = (t * t) >> 30;
        lo = 0;
        hi = 64'd1 << 30;
        while (lo < hi) begin
          mid = lo + (hi - lo + 1) / 2;
          if (pow5_q30(mid) <= t2) lo = mid;
          else hi = mid - 1;
        end
        v = (((t2 * lo) >> 30) + (64'd1 << 13)) >> 14;
      end
      tab[i] = v[LIN_W-1:0];
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin_tab();

endpackage

[hw/rtl/rgb2lab_if.sv]
interface rgb2lab_in_if;
  logic                                valid;
  logic                                ready;
  logic [rgb2lab_pkg::PIX_W-1:0]       red;
  logic [rgb2lab_pkg::PIX_W-1:0]       green;
  logic [rgb2lab_pkg::PIX_W-1:0]       blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rgb2lab_out_if;
  logic                                valid;
  logic                                ready;
  logic [rgb2lab_pkg::L_W-1:0]         lightness;
  logic signed [rgb2lab_pkg::AB_W-1:0] green_red_axis;
  logic signed [rgb2lab_pkg::AB_W-1:0] blue_yellow_axis;
  modport source (output valid, lightness, green_red_axis, blue_yellow_axis, input ready);
  modport sink   (input valid, lightness, green_red_axis, blue_yellow_axis, output ready);
endinterface

interface rgb2lab_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          index;
  logic [rgb2lab_pkg::WHITE_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/rgb_to_lab_converter.sv]
// sRGB to CIE L*a*b* pixel converter, reference white set by three registers (D65 after
// reset). Fully pipelined: one pixel per clock in and out while the output is not stalled.
// From the input transaction to the output register a pixel passes through table lookup
// and matrix, white-point division at two quotient bits a cycle, cube root at one result
// bit a cycle, then scaling and saturation. A stall on the output freezes the whole
// pipeline. Write the white point only while no pixel is in flight.
module rgb_to_lab_converter (
  input logic clk,
  input logic rst_n,
  rgb2lab_in_if.sink    in_ch,
  rgb2lab_out_if.source out_ch,
  rgb2lab_cfg_if.sink   cfg_ch
);
  import rgb2lab_pkg::*;

  localparam int SL_W = 31;

  logic en;
  logic [WHITE_W-1:0] white_r [3];
  logic [PIX_W-1:0]   pix     [3];
  logic               mat_v;
  logic [NUM_W-1:0]   num     [3];
  logic [2:0]         div_v;
  logic [RATIO_W-1:0] ratio   [3];
  logic [2:0]         f_v;
  logic [F_W-1:0]     f       [3];

  logic                   mul_v_r;
  logic signed [SL_W-1:0] l16_r;
  logic signed [SL_W-1:0] a16_r;
  logic signed [SL_W-1:0] b16_r;

  logic                   out_v_r;
  logic [L_W-1:0]         l_r;
  logic signed [AB_W-1:0] a_r;
  logic signed [AB_W-1:0] b_r;

  assign en           = !out_v_r || out_ch.ready;
  assign in_ch.ready  = en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      white_r[0] <= WHITE_X_RST;
      white_r[1] <= WHITE_Y_RST;
      white_r[2] <= WHITE_Z_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_WHITE_X: white_r[0] <= cfg_ch.data;
        CFG_WHITE_Y: white_r[1] <= cfg_ch.data;
        CFG_WHITE_Z: white_r[2] <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign pix[0] = in_ch.red;
  assign pix[1] = in_ch.green;
  assign pix[2] = in_ch.blue;

  rgb2lab_matrix u_matrix (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_ch.valid),
    .pix_i   (pix),
    .valid_o (mat_v),
    .num_o   (num)
  );

  for (genvar c = 0; c < 3; c++) begin : g_chan
    rgb2lab_div u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (mat_v),
      .num_i   (num[c]),
      .white_i (white_r[c]),
      .valid_o (div_v[c]),
      .ratio_o (ratio[c])
    );

    rgb2lab_cbrt u_cbrt (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (div_v[c]),
      .ratio_i (ratio[c]),
      .valid_o (f_v[c]),
      .f_o     (f[c])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
    end else if (en) begin
      mul_v_r <= f_v[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l16_r <= SL_W'(116) * $signed({1'b0, f[1]}) - SL_W'(32'sd16 <<< 16);
      a16_r <= SL_W'(500) * ($signed({1'b0, f[0]}) - $signed({1'b0, f[1]}));
      b16_r <= SL_W'(200) * ($signed({1'b0, f[1]}) - $signed({1'b0, f[2]}));
    end
  end

  // divide by 2^16 rounding toward zero
  function automatic logic signed [SL_W-1:0] trunc16(logic signed [SL_W-1:0] v);
    logic signed [SL_W-1:0] t;
    t = v + (v[SL_W-1] ? SL_W'(65535) : SL_W'(0));
    return t >>> 16;
  endfunction

  function automatic logic signed [AB_W-1:0] sat_ab(logic signed [SL_W-1:0] v);
    logic signed [SL_W-1:0] q;
    q = trunc16(v);
    if (q < -SL_W'(128)) return -AB_W'(128);
    else if (q > SL_W'(127)) return AB_W'(127);
    else return q[AB_W-1:0];
  endfunction

  logic signed [SL_W-1:0] l_q;
  logic [L_W-1:0]         l_sat;

  always_comb begin
    l_q = trunc16(l16_r);
    if (l_q < 0) l_sat = '0;
    else if (l_q > SL_W'(100)) l_sat = L_W'(100);
    else l_sat = l_q[L_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= mul_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l_r <= l_sat;
      a_r <= sat_ab(a16_r);
      b_r <= sat_ab(b16_r);
    end
  end

  assign out_ch.valid            = out_v_r;
  assign out_ch.lightness        = l_r;
  assign out_ch.green_red_axis   = a_r;
  assign out_ch.blue_yellow_axis = b_r;

endmodule

[hw/rtl/rgb2lab_matrix.sv]
module rgb2lab_matrix (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          valid_i,
  input  logic [rgb2lab_pkg::PIX_W-1:0] pix_i [3],
  output logic                          valid_o,
  output logic [rgb2lab_pkg::NUM_W-1:0] num_o [3]
);
  import rgb2lab_pkg::*;

  logic [3:0]        v_r;
  logic [LIN_W-1:0]  lin_r  [3];
  logic [PROD_W-1:0] prod_r [3][3];
  logic [ACC_W-1:0]  acc_r  [3];
  logic [NUM_W-1:0]  num_r  [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        lin_r[c] <= LIN_TAB[pix_i[c]];
      end
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[r][c] <= PROD_W'(COEF[r][c]) * PROD_W'(lin_r[c]);
        end
        acc_r[r] <= ACC_W'(prod_r[r][0]) + ACC_W'(prod_r[r][1]) + ACC_W'(prod_r[r][2]);
      end
    end
  end

  // times 100 as 64 + 32 + 4
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        num_r[r] <= (NUM_W'(acc_r[r]) << 6) + (NUM_W'(acc_r[r]) << 5) + (NUM_W'(acc_r[r]) << 2);
      end
    end
  end

  assign valid_o = v_r[3];
  assign num_o   = num_r;

endmodule

[hw/rtl/rgb2lab_div.sv]
module rgb2lab_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            valid_i,
  input  logic [rgb2lab_pkg::NUM_W-1:0]   num_i,
  input  logic [rgb2lab_pkg::WHITE_W-1:0] white_i,
  output logic                            valid_o,
  output logic [rgb2lab_pkg::RATIO_W-1:0] ratio_o
);
  import rgb2lab_pkg::*;

  localparam int CMP_W = DEN_W + RATIO_W + 1;

  logic [DEN_W-1:0]   den;
  logic [DIV_STAGES-1:0] v_r;
  logic [DIV_STAGES-1:0] sat_r;
  logic [NUM_W-1:0]   rem_r [DIV_STAGES];
  logic [RATIO_W-1:0] q_r   [DIV_STAGES];

  assign den = {white_i, 6'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DIV_STAGES-2:0], valid_i};
    end
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    localparam int K1 = RATIO_W - 1 - 2 * s;
    localparam int K0 = K1 - 1;
    logic [NUM_W-1:0]   rem_src;
    logic [RATIO_W-1:0] q_src;
    logic               sat_src;
    logic [CMP_W-1:0]   rem_a;
    logic [CMP_W-1:0]   rem_b;
    logic [RATIO_W-1:0] q_nxt;

    if (s == 0) begin : g_first
      // quotient of 2^24 or more saturates, zero white included
      assign rem_src = num_i;
      assign q_src   = '0;
      assign sat_src = {{(DEN_W-(NUM_W-RATIO_W)){1'b0}}, num_i[NUM_W-1:RATIO_W]} >= den;
    end else begin : g_next
      assign rem_src = rem_r[s-1];
      assign q_src   = q_r[s-1];
      assign sat_src = sat_r[s-1];
    end

    always_comb begin
      q_nxt = q_src;
      rem_a = CMP_W'(rem_src);
      if (rem_a >= (CMP_W'(den) << K1)) begin
        rem_a     = rem_a - (CMP_W'(den) << K1);
        q_nxt[K1] = 1'b1;
      end
      rem_b = rem_a;
      if (rem_b >= (CMP_W'(den) << K0)) begin
        rem_b     = rem_b - (CMP_W'(den) << K0);
        q_nxt[K0] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_b[NUM_W-1:0];
        q_r[s]   <= q_nxt;
        sat_r[s] <= sat_src;
      end
    end
  end

  assign valid_o = v_r[DIV_STAGES-1];
  assign ratio_o = sat_r[DIV_STAGES-1] ? {RATIO_W{1'b1}} : q_r[DIV_STAGES-1];

endmodule

[hw/rtl/rgb2lab_cbrt.sv]
module rgb2lab_cbrt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            valid_i,
  input  logic [rgb2lab_pkg::RATIO_W-1:0] ratio_i,
  output logic                            valid_o,
  output logic [rgb2lab_pkg::F_W-1:0]     f_o
);
  import rgb2lab_pkg::*;

  localparam int W     = 3 * F_W + 3;
  localparam int Y2_W  = 2 * F_W;
  localparam int Y3_W  = 3 * F_W;
  localparam int LP_W  = KNEE_W + F_W;

  logic [CBRT_STAGES-1:0] v_r;
  logic [CBRT_STAGES-1:0] big_r;
  logic [RATIO_W-1:0] ratio_r [CBRT_STAGES];
  logic [F_W-1:0]     lin_r   [CBRT_STAGES];
  logic [F_W-1:0]     y_r     [CBRT_STAGES];
  logic [Y2_W-1:0]    y2_r    [CBRT_STAGES];
  logic [Y3_W-1:0]    y3_r    [CBRT_STAGES];

  logic [LP_W-1:0] lin_prod;
  logic [F_W-1:0]  lin_val;

  assign lin_prod = LP_W'(ratio_i[KNEE_W-1:0]) * LP_W'(F_SLOPE);
  assign lin_val  = F_W'(lin_prod[LP_W-1:16]) + F_W'(F_OFFSET);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[CBRT_STAGES-2:0], valid_i};
    end
  end

  for (genvar s = 0; s < CBRT_STAGES; s++) begin : g_stage
    localparam int K = F_W - 1 - s;
    logic [RATIO_W-1:0] ratio_src;
    logic [F_W-1:0]     lin_src;
    logic               big_src;
    logic [F_W-1:0]     y_src;
    logic [Y2_W-1:0]    y2_src;
    logic [Y3_W-1:0]    y3_src;
    logic [W-1:0]       trial;
    logic [W-1:0]       y2_w;
    logic [W-1:0]       target;

    if (s == 0) begin : g_first
      assign ratio_src = ratio_i;
      assign lin_src   = lin_val;
      assign big_src   = ratio_i >= RATIO_W'(F_KNEE);
      assign y_src     = '0;
      assign y2_src    = '0;
      assign y3_src    = '0;
    end else begin : g_next
      assign ratio_src = ratio_r[s-1];
      assign lin_src   = lin_r[s-1];
      assign big_src   = big_r[s-1];
      assign y_src     = y_r[s-1];
      assign y2_src    = y2_r[s-1];
      assign y3_src    = y3_r[s-1];
    end

    // (y + 2^k)^3 = y^3 + 3 y^2 2^k + 3 y 2^2k + 2^3k
    always_comb begin
      target = W'(ratio_src) << 32;
      trial  = W'(y3_src)
             + (((W'(y2_src) << 1) + W'(y2_src)) << K)
             + (((W'(y_src) << 1) + W'(y_src)) << (2 * K))
             + (W'(1) << (3 * K));
      y2_w   = W'(y2_src) + (W'(y_src) << (K + 1)) + (W'(1) << (2 * K));
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ratio_r[s] <= ratio_src;
        lin_r[s]   <= lin_src;
        big_r[s]   <= big_src;
        if (trial <= target) begin
          y_r[s]  <= y_src | (F_W'(1) << K);
          y2_r[s] <= y2_w[Y2_W-1:0];
          y3_r[s] <= trial[Y3_W-1:0];
        end else begin
          y_r[s]  <= y_src;
          y2_r[s] <= y2_src;
          y3_r[s] <= y3_src;
        end
      end
    end
  end

  assign valid_o = v_r[CBRT_STAGES-1];
  assign f_o     = big_r[CBRT_STAGES-1] ? y_r[CBRT_STAGES-1] : lin_r[CBRT_STAGES-1];

endmodule

[tb/rgb_to_lab_converter_tb.sv]
module rgb_to_lab_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgb2lab_pkg::*;

  localparam int PIPE_LATENCY = 37;
  localparam int DRAIN_LIMIT  = 20000;
  localparam logic [1:0] CFG_UNMAPPED = 2'd3;
  localparam int RANDOM_PER_PHASE = 70;

  typedef struct {
    logic [PIX_W-1:0]       red;
    logic [PIX_W-1:0]       green;
    logic [PIX_W-1:0]       blue;
  } pixel_t;

  typedef struct {
    logic [L_W-1:0]         lightness;
    logic signed [AB_W-1:0] green_red_axis;
    logic signed [AB_W-1:0] blue_yellow_axis;
  } lab_t;

  typedef struct {
    pixel_t pix;
    bit     typed;
    lab_t   lab;
  } pixel_row_t;

  logic clk;
  logic rst_n;

  rgb2lab_in_if  in_bus ();
  rgb2lab_out_if out_bus ();
  rgb2lab_cfg_if cfg_bus ();

  rgb_to_lab_converter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  logic [LIN_W-1:0]   srgb_lin [TAB_N];
  logic [WHITE_W-1:0] white_pt [3];
  lab_t               pending_lab [$];
  int                 err_count;
  int                 burst_left;
  longint unsigned    cyc = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic longint unsigned fifth_power_q30(longint unsigned y);
    longint unsigned p;
    p = y;
    for (int k = 0; k < 4; k++) p = (p * y) >> 30;
    return p;
  endfunction

  // srgb decode curve, gamma segment via fifth root of t^2
  function automatic void fill_srgb_lin();
    longint unsigned t, t2, lo, hi, mid;
    for (int i = 0; i < TAB_N; i++) begin
      if (i <= 10) begin
        srgb_lin[i] = LIN_W'((longint'(i) * 13107200 + 329460) / 658920);
      end else begin
        t  = (longint'(40 * i + 561) << 30) / 10761;
        t2 = (t * t) >> 30;
        lo = 0;
        hi = 64'd1 << 30;
        while (lo < hi) begin
          mid = lo + (hi - lo + 1) / 2;
          if (fifth_power_q30(mid) <= t2) lo = mid;
          else hi = mid - 1;
        end
        srgb_lin[i] = LIN_W'((((t2 * lo) >> 30) + (64'd1 << 13)) >> 14);
      end
    end
  endfunction

  function automatic longint cie_f(longint unsigned acc, logic [WHITE_W-1:0] w);
    longint unsigned r, cube, lo, hi, mid;
    if (w == 0) r = 64'hFF_FFFF;
    else begin
      r = (acc * 100) / (64 * longint'(w));
      if (r > 64'hFF_FFFF) r = 64'hFF_FFFF;
    end
    if (r < F_KNEE) return longint'(((r * F_SLOPE) >> 16) + F_OFFSET);
    cube = r << 32;
    lo = 0;
    hi = (64'd1 << F_W) - 1;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (mid * mid * mid <= cube) lo = mid;
      else hi = mid - 1;
    end
    return longint'(lo);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic lab_t convert_pixel(pixel_t p);
    longint unsigned lin [3];
    longint unsigned acc [3];
    longint fx, fy, fz;
    lab_t res;
    lin[0] = srgb_lin[p.red];
    lin[1] = srgb_lin[p.green];
    lin[2] = srgb_lin[p.blue];
    for (int row = 0; row < 3; row++) begin
      acc[row] = 0;
      for (int col = 0; col < 3; col++) acc[row] += longint'(COEF[row][col]) * lin[col];
    end
    fx = cie_f(acc[0], white_pt[0]);
    fy = cie_f(acc[1], white_pt[1]);
    fz = cie_f(acc[2], white_pt[2]);
    res.lightness        = L_W'(clamp((116 * fy - 16 * 65536) / 65536, 0, 100));
    res.green_red_axis   = AB_W'(clamp((500 * (fx - fy)) / 65536, -128, 127));
    res.blue_yellow_axis = AB_W'(clamp((200 * (fy - fz)) / 65536, -128, 127));
    return res;
  endfunction

  task automatic write_white(input logic [1:0] idx, input logic [WHITE_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    if (idx != CFG_UNMAPPED) white_pt[idx] = val;
    @(posedge clk);
  endtask

  // sender bursts: valid stays high inside a burst, drops for a random gap between
  task automatic send_pixel(input pixel_t p, input bit typed, input lab_t lab);
    if (burst_left == 0) begin
      in_bus.valid <= 1'b0;
      in_bus.red   <= PIX_W'($urandom);
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_bus.valid <= 1'b1;
    in_bus.red   <= p.red;
    in_bus.green <= p.green;
    in_bus.blue  <= p.blue;
    do @(posedge clk); while (!in_bus.ready);
    pending_lab.push_back(typed ? lab : convert_pixel(p));
  endtask

  task automatic settle();
    in_bus.valid <= 1'b0;
    burst_left = 0;
    while (pending_lab.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  function automatic pixel_t random_pixel();
    pixel_t p;
    logic [PIX_W-1:0] gray;
    case ($urandom_range(0, 9))
      0: begin
        p.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      1: begin
        gray = PIX_W'($urandom);
        p.red = gray; p.green = gray; p.blue = gray;
      end
      2: begin
        p.red = PIX_W'($urandom_range(0, 12));
        p.green = PIX_W'($urandom_range(0, 12));
        p.blue = PIX_W'($urandom_range(0, 12));
      end
      default: begin
        p.red = PIX_W'($urandom); p.green = PIX_W'($urandom); p.blue = PIX_W'($urandom);
      end
    endcase
    return p;
  endfunction

  task automatic random_phase(input int n);
    lab_t none;
    none = '{default: '0};
    for (int i = 0; i < n; i++) send_pixel(random_pixel(), 1'b0, none);
    settle();
  endtask

  // receiver stall pattern, cycles through several modes
  always @(posedge clk) begin
    cyc <= cyc + 1;
    case ((cyc / 300) % 4)
      0: out_bus.ready <= 1'b1;
      1: out_bus.ready <= $urandom_range(0, 1);
      2: out_bus.ready <= (cyc % 16) < 11;
      default: out_bus.ready <= $urandom_range(0, 5) == 0;
    endcase
  end

  always @(posedge clk) begin
    lab_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_lab.size() == 0) begin
        $error("result transaction with no expectation pending");
        err_count++;
      end else begin
        want = pending_lab.pop_front();
        if (out_bus.lightness !== want.lightness) begin
          $error("lightness: expected %0d, actual %0d", want.lightness, out_bus.lightness);
          err_count++;
        end
        if (out_bus.green_red_axis !== want.green_red_axis) begin
          $error("green_red_axis: expected %0d, actual %0d",
                 want.green_red_axis, out_bus.green_red_axis);
          err_count++;
        end
        if (out_bus.blue_yellow_axis !== want.blue_yellow_axis) begin
          $error("blue_yellow_axis: expected %0d, actual %0d",
                 want.blue_yellow_axis, out_bus.blue_yellow_axis);
          err_count++;
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("rgb_to_lab_converter regression: fail");
    $finish;
  end

  initial begin
    pixel_row_t rows [$];
    lab_t zero_lab;
    int waited;
    zero_lab = '{default: '0};
    err_count = 0;
    burst_left = 0;
    fill_srgb_lin();
    white_pt[0] = WHITE_X_RST;
    white_pt[1] = WHITE_Y_RST;
    white_pt[2] = WHITE_Z_RST;
    rst_n         <= 1'b0;
    in_bus.valid  <= 1'b0;
    in_bus.red    <= '0;
    in_bus.green  <= '0;
    in_bus.blue   <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= CFG_WHITE_X;
    cfg_bus.data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // black gives exactly zero under the reset white point
    rows = '{
      '{'{8'd0, 8'd0, 8'd0}, 1'b1, zero_lab},
      '{'{8'd255, 8'd255, 8'd255}, 1'b0, zero_lab},
      '{'{8'd255, 8'd0, 8'd0}, 1'b0, zero_lab},
      '{'{8'd0, 8'd255, 8'd0}, 1'b0, zero_lab},
      '{'{8'd0, 8'd0, 8'd255}, 1'b0, zero_lab},
      '{'{8'd0, 8'd255, 8'd255}, 1'b0, zero_lab},
      '{'{8'd255, 8'd0, 8'd255}, 1'b0, zero_lab},
      '{'{8'd255, 8'd255, 8'd0}, 1'b0, zero_lab},
      '{'{8'd1, 8'd0, 8'd0}, 1'b0, zero_lab},
      '{'{8'd0, 8'd1, 8'd0}, 1'b0, zero_lab},
      '{'{8'd0, 8'd0, 8'd1}, 1'b0, zero_lab},
      '{'{8'd10, 8'd10, 8'd10}, 1'b0, zero_lab},
      '{'{8'd11, 8'd11, 8'd11}, 1'b0, zero_lab},
      '{'{8'd128, 8'd128, 8'd128}, 1'b0, zero_lab},
      '{'{8'd170, 8'd85, 8'd170}, 1'b0, zero_lab},
      '{'{8'd85, 8'd170, 8'd85}, 1'b0, zero_lab},
      '{'{8'd254, 8'd127, 8'd1}, 1'b0, zero_lab},
      '{'{8'd0, 8'd0, 8'd0}, 1'b1, zero_lab}
    };
    foreach (rows[i]) send_pixel(rows[i].pix, rows[i].typed, rows[i].lab);
    settle();

    random_phase(RANDOM_PER_PHASE);

    // zero white point: every ratio saturates
    write_white(CFG_WHITE_X, '0);
    write_white(CFG_WHITE_Y, '0);
    write_white(CFG_WHITE_Z, '0);
    send_pixel('{8'd0, 8'd0, 8'd0}, 1'b0, zero_lab);
    random_phase(20);

    write_white(CFG_WHITE_X, 17'h1FFFF);
    write_white(CFG_WHITE_Y, 17'h1FFFF);
    write_white(CFG_WHITE_Z, 17'h1FFFF);
    random_phase(RANDOM_PER_PHASE);

    write_white(CFG_WHITE_X, 17'd1);
    write_white(CFG_WHITE_Y, 17'd1);
    write_white(CFG_WHITE_Z, 17'd1);
    random_phase(20);

    // lopsided white points push a and b into saturation both ways
    write_white(CFG_WHITE_X, 17'd4000);
    write_white(CFG_WHITE_Y, 17'h1FFFF);
    write_white(CFG_WHITE_Z, 17'd500);
    random_phase(RANDOM_PER_PHASE / 2);
    write_white(CFG_WHITE_X, 17'h1FFFF);
    write_white(CFG_WHITE_Y, 17'd3000);
    write_white(CFG_WHITE_Z, 17'h1FFFF);
    random_phase(RANDOM_PER_PHASE / 2);

    for (int ph = 0; ph < 2; ph++) begin
      write_white(CFG_WHITE_X, WHITE_W'($urandom_range(1, 131071)));
      write_white(CFG_WHITE_Y, WHITE_W'($urandom_range(1, 131071)));
      write_white(CFG_WHITE_Z, WHITE_W'($urandom_range(1, 131071)));
      random_phase(RANDOM_PER_PHASE / 2);
    end

    write_white(CFG_WHITE_X, WHITE_X_RST);
    write_white(CFG_WHITE_Y, WHITE_Y_RST);
    write_white(CFG_WHITE_Z, WHITE_Z_RST);
    // unmapped register index must leave the white point alone
    write_white(CFG_UNMAPPED, 17'd5);
    random_phase(RANDOM_PER_PHASE);

    waited = 0;
    while (pending_lab.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_LATENCY * 2) @(posedge clk);
    if (pending_lab.size() != 0) begin
      $error("%0d expected results never arrived", pending_lab.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("rgb_to_lab_converter regression: pass");
    end else begin
      $display("rgb_to_lab_converter regression: fail");
    end
    $finish;
  end

endmodule

[rgb_to_lab_converter.f]
hw/rtl/rgb2lab_pkg.sv
hw/rtl/rgb2lab_if.sv
hw/rtl/rgb2lab_matrix.sv
hw/rtl/rgb2lab_div.sv
hw/rtl/rgb2lab_cbrt.sv
hw/rtl/rgb_to_lab_converter.sv
tb/rgb_to_lab_converter_tb.sv
